// ===== src/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared constants, request/status codes and the result type of the
// length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    // Ring size in bytes; a power of two so that positions wrap naturally.
    localparam int CAPACITY     = 1024;
    localparam int PTR_W        = $clog2(CAPACITY);
    localparam int USED_W       = PTR_W + 1;
    localparam int PREFIX_BYTES = 4;
    localparam int MAX_MSG_LEN  = CAPACITY - PREFIX_BYTES;

    // Fixed field widths of the interface.
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 10;
    localparam int COUNT_W = 9;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE_BEGIN = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_BYTE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ_BEGIN  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_BYTE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLOSE       = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_CLOSED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_SHORT     = 3'd5;
    localparam logic [STAT_W-1:0] ST_SEQ       = 3'd6;

    // Transfer modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LEN_W-1:0]   message_length;
        logic [BYTE_W-1:0]  data_out_byte;
        logic               last_byte;
        logic [COUNT_W-1:0] message_count;
        logic [LEN_W-1:0]   stored_payload;
        logic               end_of_stream;
    } rsp_t;

endpackage

// ===== src/lpmr_ram.sv =====
// ----------------------------------------------------------------------------
// lpmr_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data (held while no read is issued).
// ----------------------------------------------------------------------------
module lpmr_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lpmr_out.sv =====
// ----------------------------------------------------------------------------
// lpmr_out
// Output register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module lpmr_out (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lpmr_pkg::rsp_t rsp_in,
    input  logic         rsp_ready,
    output logic         rsp_valid,
    output lpmr_pkg::rsp_t rsp_out,
    output logic         slot_free
);
    import lpmr_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign slot_free  = !valid_reg || rsp_ready;
    assign valid_next = push ? 1'b1 : (rsp_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= rsp_in;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_out   = data_reg;

endmodule

// ===== src/lpmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Request sequencer: holds queue and transfer state, drives the ring RAM
// and builds one result per request.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [lpmr_pkg::REQ_W-1:0]    req_type,
    input  logic [lpmr_pkg::WORD_W-1:0]   msg_len,
    input  logic [lpmr_pkg::BYTE_W-1:0]   data_in_byte,
    input  logic [lpmr_pkg::WORD_W-1:0]   reader_capacity,
    output logic                          mem_we,
    output logic [lpmr_pkg::PTR_W-1:0]    mem_waddr,
    output logic [lpmr_pkg::BYTE_W-1:0]   mem_wdata,
    output logic                          mem_re,
    output logic [lpmr_pkg::PTR_W-1:0]    mem_raddr,
    input  logic [lpmr_pkg::BYTE_W-1:0]   mem_rdata,
    input  logic                          slot_free,
    output logic                          push,
    output lpmr_pkg::rsp_t                rsp
);
    import lpmr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WPFX = 2'd2;
    localparam logic [1:0] S_RPFX = 2'd3;

    localparam int HI_W = LEN_W - BYTE_W;

    // control and queue state
    logic [1:0]         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0] held_reg, held_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic               closed_reg, closed_next;
    logic [1:0]         mode_reg, mode_next;
    logic [PTR_W-1:0]   xptr_reg, xptr_next;
    logic [LEN_W-1:0]   xrem_reg, xrem_next;
    logic [LEN_W-1:0]   xlen_reg, xlen_next;
    logic [1:0]         pcnt_reg, pcnt_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [HI_W-1:0]    hi_reg, hi_next;

    // latched request
    logic [REQ_W-1:0]   rtype_reg;
    logic [WORD_W-1:0]  rlen_reg;
    logic [BYTE_W-1:0]  rbyte_reg;
    logic [WORD_W-1:0]  rcap_reg;

    logic               accept;
    logic               done;
    logic [STAT_W-1:0]  res_status;
    logic [LEN_W-1:0]   res_len;
    logic [BYTE_W-1:0]  res_byte;
    logic               res_last;
    logic               do_step, do_finish, do_commit, do_pop, do_close;
    logic               do_open_wr, do_open_rd;
    logic [LEN_W-1:0]   clen, plen, olen;
    logic [LEN_W-1:0]   hlen;
    logic [PTR_W-1:0]   tail;
    logic [USED_W-1:0]  need, room;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign tail      = head_reg + used_reg[PTR_W-1:0];
    assign need      = USED_W'(rlen_reg[LEN_W-1:0]) + USED_W'(PREFIX_BYTES);
    assign room      = USED_W'(CAPACITY) - used_reg;
    assign hlen      = {hi_reg, mem_rdata};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        used_next   = used_reg;
        held_next   = held_reg;
        total_next  = total_reg;
        closed_next = closed_reg;
        mode_next   = mode_reg;
        xptr_next   = xptr_reg;
        xrem_next   = xrem_reg;
        xlen_next   = xlen_reg;
        pcnt_next   = pcnt_reg;
        tail_next   = tail_reg;
        hi_next     = hi_reg;

        mem_we     = 1'b0;
        mem_waddr  = xptr_reg;
        mem_wdata  = rbyte_reg;
        mem_re     = 1'b0;
        mem_raddr  = xptr_reg;

        done       = 1'b0;
        res_status = ST_OK;
        res_len    = '0;
        res_byte   = '0;
        res_last   = 1'b0;
        do_step    = 1'b0;
        do_finish  = 1'b0;
        do_commit  = 1'b0;
        do_pop     = 1'b0;
        do_close   = 1'b0;
        do_open_wr = 1'b0;
        do_open_rd = 1'b0;
        clen       = '0;
        plen       = '0;
        olen       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // read ahead: byte two of the head prefix, or the next payload byte
                if (accept)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (req_type == REQ_READ_BEGIN) ? head_reg + PTR_W'(2)
                                                              : xptr_reg;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (rtype_reg)
                    REQ_WRITE_BEGIN:
                    begin
                        priority if (mode_reg != MODE_IDLE)
                        begin
                            res_status = ST_SEQ;
                            done       = 1'b1;
                        end
                        else if (closed_reg)
                        begin
                            res_status = ST_CLOSED;
                            done       = 1'b1;
                        end
                        else if (rlen_reg > WORD_W'(MAX_MSG_LEN))
                        begin
                            res_status = ST_TOO_LARGE;
                            done       = 1'b1;
                        end
                        else if (need > room)
                        begin
                            res_status = ST_FULL;
                            done       = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = tail;
                            mem_wdata  = rlen_reg[31:24];
                            tail_next  = tail;
                            pcnt_next  = 2'd1;
                            state_next = S_WPFX;
                        end
                    end
                    REQ_WRITE_BYTE:
                    begin
                        done = 1'b1;
                        if (mode_reg != MODE_WRITE)
                        begin
                            res_status = ST_SEQ;
                        end
                        else
                        begin
                            mem_we  = 1'b1;
                            do_step = 1'b1;
                            if (xrem_reg == LEN_W'(1))
                            begin
                                res_last  = 1'b1;
                                do_commit = 1'b1;
                                do_finish = 1'b1;
                                clen      = xlen_reg;
                            end
                        end
                    end
                    REQ_READ_BEGIN:
                    begin
                        priority if (mode_reg != MODE_IDLE)
                        begin
                            res_status = ST_SEQ;
                            done       = 1'b1;
                        end
                        else if (held_reg == '0)
                        begin
                            res_status = ST_EMPTY;
                            done       = 1'b1;
                        end
                        else
                        begin
                            // committed lengths fit in the low prefix bytes
                            hi_next    = mem_rdata[HI_W-1:0];
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg + PTR_W'(3);
                            state_next = S_RPFX;
                        end
                    end
                    REQ_READ_BYTE:
                    begin
                        done = 1'b1;
                        if (mode_reg != MODE_READ)
                        begin
                            res_status = ST_SEQ;
                        end
                        else
                        begin
                            res_byte = mem_rdata;
                            do_step  = 1'b1;
                            if (xrem_reg == LEN_W'(1))
                            begin
                                res_last  = 1'b1;
                                do_pop    = 1'b1;
                                do_finish = 1'b1;
                                plen      = xlen_reg;
                            end
                        end
                    end
                    REQ_CLOSE:
                    begin
                        done     = 1'b1;
                        do_close = 1'b1;
                    end
                    default:
                    begin
                        res_status = ST_SEQ;
                        done       = 1'b1;
                    end
                endcase
            end
            S_WPFX:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg + PTR_W'(pcnt_reg);
                unique case (pcnt_reg)
                    2'd0: mem_wdata = rlen_reg[31:24];
                    2'd1: mem_wdata = rlen_reg[23:16];
                    2'd2: mem_wdata = rlen_reg[15:8];
                    2'd3: mem_wdata = rlen_reg[7:0];
                endcase
                if (pcnt_reg == 2'd3)
                begin
                    done = 1'b1;
                    if (rlen_reg[LEN_W-1:0] == '0)
                    begin
                        do_commit = 1'b1;
                    end
                    else
                    begin
                        do_open_wr = 1'b1;
                        olen       = rlen_reg[LEN_W-1:0];
                    end
                end
                else
                begin
                    pcnt_next = pcnt_reg + 2'd1;
                end
            end
            S_RPFX:
            begin
                done    = 1'b1;
                res_len = hlen;
                priority if (rcap_reg < WORD_W'(hlen))
                begin
                    res_status = ST_SHORT;
                end
                else if (hlen == '0)
                begin
                    do_pop = 1'b1;
                end
                else
                begin
                    do_open_rd = 1'b1;
                    olen       = hlen;
                end
            end
        endcase

        // every queue and transfer state change of a request lands on the beat that carries its result
        push = done && slot_free;
        if (done)
        begin
            state_next = push ? S_IDLE : state_reg;
        end
        if (push)
        begin
            if (do_step)
            begin
                xptr_next = xptr_reg + PTR_W'(1);
                xrem_next = xrem_reg - LEN_W'(1);
            end
            if (do_finish)
            begin
                mode_next = MODE_IDLE;
            end
            if (do_commit)
            begin
                used_next  = used_reg + USED_W'(clen) + USED_W'(PREFIX_BYTES);
                total_next = total_reg + clen;
                held_next  = held_reg + COUNT_W'(1);
            end
            if (do_pop)
            begin
                head_next  = head_reg + PTR_W'(plen) + PTR_W'(PREFIX_BYTES);
                used_next  = used_reg - USED_W'(plen) - USED_W'(PREFIX_BYTES);
                total_next = total_reg - plen;
                held_next  = held_reg - COUNT_W'(1);
            end
            if (do_close)
            begin
                closed_next = 1'b1;
            end
            if (do_open_wr)
            begin
                mode_next = MODE_WRITE;
                xptr_next = tail_reg + PTR_W'(PREFIX_BYTES);
                xrem_next = olen;
                xlen_next = olen;
            end
            if (do_open_rd)
            begin
                mode_next = MODE_READ;
                xptr_next = head_reg + PTR_W'(PREFIX_BYTES);
                xrem_next = olen;
                xlen_next = olen;
            end
        end

        rsp.status         = res_status;
        rsp.message_length = res_len;
        rsp.data_out_byte  = res_byte;
        rsp.last_byte      = res_last;
        rsp.message_count  = held_next;
        rsp.stored_payload = total_next;
        rsp.end_of_stream  = closed_next && (held_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            used_reg   <= '0;
            held_reg   <= '0;
            total_reg  <= '0;
            closed_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            xptr_reg   <= '0;
            xrem_reg   <= '0;
            xlen_reg   <= '0;
            pcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            used_reg   <= used_next;
            held_reg   <= held_next;
            total_reg  <= total_next;
            closed_reg <= closed_next;
            mode_reg   <= mode_next;
            xptr_reg   <= xptr_next;
            xrem_reg   <= xrem_next;
            xlen_reg   <= xlen_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        hi_reg   <= hi_next;
        if (accept)
        begin
            rtype_reg <= req_type;
            rlen_reg  <= msg_len;
            rbyte_reg <= data_in_byte;
            rcap_reg  <= reader_capacity;
        end
    end

endmodule

// ===== src/length_prefixed_message_ring.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Byte ring holding whole messages behind 4-byte big-endian length prefixes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries one request per beat:
//   write_begin, write_byte, read_begin, read_byte or close. Response channel
//   (rsp_valid/rsp_ready) returns exactly one result beat per request.
//   Requests are handled one at a time; req_ready is high while the
//   sequencer is idle. A result appears on rsp_* in the cycle after its last
//   execute cycle. write_byte, read_byte, close and rejected requests
//   finish in the execute state; read_begin goes on to the prefix read
//   state, and an accepted write_begin to the prefix write state, which
//   writes the remaining prefix bytes. The ring RAM has one port per
//   direction: one byte moves per cycle, reads are registered, and a
//   prefix is four bytes.
//   Reset empties the queue, clears the closed flag and any open transfer;
//   the RAM contents are not cleared (only committed bytes are ever returned).
//   When the receiver stalls, one result waits in the output register and
//   the next request is still accepted; its result (and its state update)
//   holds until the output register frees up.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [lpmr_pkg::REQ_W-1:0]    req_type,
    input  logic [lpmr_pkg::WORD_W-1:0]   msg_len,
    input  logic [lpmr_pkg::BYTE_W-1:0]   data_in_byte,
    input  logic [lpmr_pkg::WORD_W-1:0]   reader_capacity,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [lpmr_pkg::STAT_W-1:0]   status,
    output logic [lpmr_pkg::LEN_W-1:0]    message_length,
    output logic [lpmr_pkg::BYTE_W-1:0]   data_out_byte,
    output logic                          last_byte,
    output logic [lpmr_pkg::COUNT_W-1:0]  message_count,
    output logic [lpmr_pkg::LEN_W-1:0]    stored_payload,
    output logic                          end_of_stream
);
    import lpmr_pkg::*;

    // RAM ports
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    // sequencer to output register
    logic               push;
    logic               slot_free;
    rsp_t               rsp_new;
    rsp_t               rsp_cur;

    // Ring storage. Writes and reads never touch the same entry in one cycle:
    // requests run one at a time and no state both reads and writes the RAM, so
    // no forwarding path is needed.
    lpmr_ram #(
        .ADDR_W (PTR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer: decode, checks, prefix handling and queue bookkeeping.
    lpmr_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_type        (req_type),
        .msg_len         (msg_len),
        .data_in_byte    (data_in_byte),
        .reader_capacity (reader_capacity),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .slot_free       (slot_free),
        .push            (push),
        .rsp             (rsp_new)
    );

    // Output register decouples the receiver from the sequencer.
    lpmr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rsp_in    (rsp_new),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_out   (rsp_cur),
        .slot_free (slot_free)
    );

    assign status         = rsp_cur.status;
    assign message_length = rsp_cur.message_length;
    assign data_out_byte  = rsp_cur.data_out_byte;
    assign last_byte      = rsp_cur.last_byte;
    assign message_count  = rsp_cur.message_count;
    assign stored_payload = rsp_cur.stored_payload;
    assign end_of_stream  = rsp_cur.end_of_stream;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // one request in flight: an accepted request blocks the next beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");

    // a completed message byte only comes with an ok status and no length
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && last_byte) |-> (status == ST_OK && message_length == '0))
        else $error("last_byte on a result that is not a plain ok");

    // end of stream means nothing is left in the queue
    a_eos_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && end_of_stream) |-> (message_count == '0 && stored_payload == '0))
        else $error("end_of_stream with messages still queued");

    // empty is only reported on an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |-> (message_count == '0))
        else $error("empty reported with messages held");

endmodule
